### design/utf8_glyph_lookup_metrics_assert.svh
// assertion macros for the utf8 glyph lookup block
// included by modules that carry concurrent checks
`ifndef UTF8_GLYPH_LOOKUP_METRICS_ASSERT_SVH
`define UTF8_GLYPH_LOOKUP_METRICS_ASSERT_SVH
`ifndef SYNTHESIS
`define UGL_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define UGL_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define UGL_ASSERT_IMP(label, clk, rst_n, a, c)
`define UGL_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### design/ugl_pkg.sv
// shared types and constants for the utf8 glyph lookup block
// no dependencies
package ugl_pkg;
  localparam int NUM_RANGES = 64;
  localparam int NUM_GLYPHS = 1024;
  localparam int RIDX_W = $clog2(NUM_RANGES);
  localparam int GIDX_W = $clog2(NUM_GLYPHS);

  typedef enum logic [1:0] {
    CMD_RANGE = 2'd0, CMD_GLYPH = 2'd1, CMD_TEXT = 2'd2, CMD_END = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FOUND = 2'd0, KIND_METRICS = 2'd1, KIND_MISSING = 2'd2, KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic {
    REG_SPACING = 1'b0, REG_RCOUNT = 1'b1
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROBE, ST_CMP, ST_FINAL, ST_GREAD, ST_GWAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  text_byte;
    logic [9:0]  entry_index;
    logic [15:0] range_first_code;
    logic [10:0] range_length;
    logic [9:0]  range_glyph_base;
    logic [11:0] glyph_sprite_x;
    logic [11:0] glyph_sprite_y;
    logic [7:0]  glyph_w;
    logic [7:0]  glyph_h;
    logic [7:0]  glyph_baseline;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code_point;
    logic [11:0] out_sprite_x;
    logic [11:0] out_sprite_y;
    logic [7:0]  out_width;
    logic [7:0]  out_height;
    logic [7:0]  out_baseline;
    logic [15:0] pen_x;
    logic [15:0] line_width;
    logic [7:0]  above_baseline;
    logic [7:0]  below_baseline;
  } out_item_t;

  typedef struct packed {
    logic [15:0] first;
    logic [10:0] len;
    logic [9:0]  base;
  } range_rec_t;

  typedef struct packed {
    logic [7:0]  bl;
    logic [7:0]  h;
    logic [7:0]  w;
    logic [11:0] sy;
    logic [11:0] sx;
  } glyph_rec_t;

  // search control between sequencer and search unit
  typedef struct packed {
    logic start;
    logic step;
  } srch_ctl_t;
endpackage

### design/ugl_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module ugl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### design/ugl_search.sv
// binary search bounds over the range table, one probe per step
// depends on ugl_pkg
module ugl_search
  import ugl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  srch_ctl_t         ctl,
  input  logic [6:0]        range_count,
  input  logic [15:0]       code,
  input  range_rec_t        probe,
  output logic [RIDX_W-1:0] addr,
  output logic              done,
  output logic              empty
);
  logic [RIDX_W:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [RIDX_W:0] n;
  logic [RIDX_W+1:0] sum;
  logic [RIDX_W:0] mid;
  logic [16:0] pend;

  always_comb begin
    n = (range_count > 7'(NUM_RANGES)) ? (RIDX_W+1)'(NUM_RANGES)
                                       : (RIDX_W+1)'(range_count);
    sum = {1'b0, lo_r} + {1'b0, hi_r};
    mid = sum[RIDX_W+1:1];
    pend = {1'b0, probe.first} + 17'(probe.len);
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (ctl.start) begin
      lo_nxt = '0;
      hi_nxt = (n == 0) ? '0 : n - 1'b1;
    end else if (ctl.step) begin
      if (pend > {1'b0, code}) hi_nxt = mid;
      else lo_nxt = mid + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign done  = !(lo_r < hi_r);
  assign addr  = done ? lo_r[RIDX_W-1:0] : mid[RIDX_W-1:0];
  assign empty = (n == 0);
endmodule

### design/utf8_glyph_lookup_metrics.sv
// Decodes utf8 text items into code points, looks each one up in a loaded table of sorted
// code-point ranges and reports the glyph record with its pen x; an end-of-line item reports
// the line width and the extents above and below the baseline. A byte that completes a
// character holds the input from its acceptance until its lookup is done: a probe state,
// a read and a compare phase per search step, a final range check, a glyph-store read, a
// wait for its data and the output state; with no ranges the probe goes straight to the
// output state. Table writes, partial utf8 bytes, dropped bytes and end of line start no
// lookup. While a result waits unread the input is held off; the next item can be taken in
// the cycle the result leaves.
// top level: utf8 decoder, sequencer, search unit and stores
// depends on ugl_pkg, ugl_ram, ugl_search, utf8_glyph_lookup_metrics_assert.svh
`include "utf8_glyph_lookup_metrics_assert.svh"
module utf8_glyph_lookup_metrics
  import ugl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [6:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [3:0]  spacing_r;
  logic [6:0]  rcount_r;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] part_r, part_nxt;
  logic [15:0] acc_r;
  logic [7:0]  above_r, below_r;
  logic [15:0] code_r, code_nxt;
  logic        ov_r;
  out_item_t   od_r;
  logic        accept, lookup;
  srch_ctl_t   sctl;
  logic [RIDX_W-1:0] saddr;
  logic        sdone, sempty;
  range_rec_t  rrd;
  glyph_rec_t  grd;
  logic [GIDX_W-1:0] graddr_r;
  logic        gok_r;
  logic        emit_r;
  logic [16:0] gsum;
  logic [15:0] off;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE) && !(ov_r && !out_ready) && !emit_r;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= 4'd1;
      rcount_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPACING: spacing_r <= cfg_data[3:0];
        REG_RCOUNT:  rcount_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // utf8 decode on accept
  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    code_nxt = code_r;
    lookup   = 1'b0;
    if (accept) begin
      case (in_data.command)
        CMD_TEXT: begin
          if (pend_r != 0) begin
            part_nxt = {part_r[9:0], in_data.text_byte[5:0]};
            pend_nxt = pend_r - 1'b1;
            if (pend_r == 2'd1) begin
              lookup = 1'b1;
              code_nxt = part_nxt;
              part_nxt = '0;
            end
          end else if (!in_data.text_byte[7]) begin
            lookup = 1'b1;
            code_nxt = {8'd0, in_data.text_byte};
          end else if (in_data.text_byte[7:5] == 3'b110) begin
            part_nxt = {11'd0, in_data.text_byte[4:0]};
            pend_nxt = 2'd1;
          end else if (in_data.text_byte[7:4] == 4'b1110) begin
            part_nxt = {12'd0, in_data.text_byte[3:0]};
            pend_nxt = 2'd2;
          end
        end
        CMD_END: begin
          pend_nxt = '0;
          part_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (lookup) state_nxt = ST_PROBE;
      ST_PROBE: state_nxt = sempty ? ST_EMIT : ST_CMP;
      ST_CMP:   state_nxt = sdone ? ST_FINAL : ST_CMP;
      ST_FINAL: state_nxt = ST_GREAD;
      ST_GREAD: state_nxt = ST_GWAIT;
      ST_GWAIT: state_nxt = ST_EMIT;
      ST_EMIT:  if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic cmp_ph_r;

  always_comb begin
    sctl.start = (state_r == ST_IDLE);
    sctl.step  = (state_r == ST_CMP) && !sdone && !cmp_ph_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      part_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      part_r  <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  ugl_search u_search (
    .clk(clk), .rst_n(rst_n), .ctl(sctl), .range_count(rcount_r),
    .code(code_r), .probe(rrd), .addr(saddr), .done(sdone), .empty(sempty)
  );

  // range read data is valid in the cycle after its address; ST_CMP waits on it
  logic rwe, gwe;
  assign rwe = accept && (in_data.command == CMD_RANGE)
               && (in_data.entry_index < 10'(NUM_RANGES));
  assign gwe = accept && (in_data.command == CMD_GLYPH)
               && ({1'b0, in_data.entry_index} < 11'(NUM_GLYPHS));

  ugl_ram #(.WIDTH($bits(range_rec_t)), .DEPTH(NUM_RANGES)) u_ranges (
    .clk(clk), .we(rwe), .waddr(in_data.entry_index[RIDX_W-1:0]),
    .wdata({in_data.range_first_code, in_data.range_length, in_data.range_glyph_base}),
    .raddr(saddr), .rdata(rrd)
  );

  ugl_ram #(.WIDTH($bits(glyph_rec_t)), .DEPTH(NUM_GLYPHS)) u_glyphs (
    .clk(clk), .we(gwe), .waddr(in_data.entry_index[GIDX_W-1:0]),
    .wdata({in_data.glyph_baseline, in_data.glyph_h, in_data.glyph_w,
            in_data.glyph_sprite_y, in_data.glyph_sprite_x}),
    .raddr(graddr_r), .rdata(grd)
  );

  // final range check in ST_FINAL (rrd holds the entry at lo)
  always_comb begin
    off  = code_r - rrd.first;
    gsum = {7'd0, rrd.base} + {1'b0, off};
  end

  // compare cycles alternate with read cycles
  always_ff @(posedge clk) begin
    if (!rst_n) cmp_ph_r <= 1'b0;
    else cmp_ph_r <= (state_r == ST_CMP) && !cmp_ph_r;
    if (state_r == ST_FINAL) begin
      graddr_r <= gsum[GIDX_W-1:0];
      gok_r <= (code_r >= rrd.first)
               && ({1'b0, code_r} < {1'b0, rrd.first} + 17'(rrd.len))
               && (gsum < 17'(NUM_GLYPHS));
    end else if (state_r == ST_PROBE && sempty) begin
      gok_r <= 1'b0;
    end
  end

  // output register and line metrics
  logic [7:0]  above;
  logic [16:0] nacc;
  logic [15:0] lw;
  logic        ov_nxt;
  out_item_t   od_nxt;
  logic [15:0] acc_nxt;
  logic [7:0]  above_nxt, below_nxt;
  always_comb begin
    above = (grd.h > grd.bl) ? grd.h - grd.bl : 8'd0;
    nacc  = {1'b0, acc_r} + 17'(grd.w) + 17'(spacing_r);
    if (acc_r == 16'hFFFF) lw = 16'hFFFF;
    else if (acc_r != 0) lw = (acc_r >= 16'(spacing_r)) ? acc_r - 16'(spacing_r) : '0;
    else lw = '0;
  end

  always_comb begin
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    acc_nxt   = acc_r;
    above_nxt = above_r;
    below_nxt = below_r;
    if (accept && in_data.command == CMD_END) begin
      ov_nxt = 1'b1;
      od_nxt = '0;
      od_nxt.kind = KIND_METRICS;
      od_nxt.line_width = lw;
      od_nxt.above_baseline = above_r;
      od_nxt.below_baseline = below_r;
      acc_nxt   = '0;
      above_nxt = '0;
      below_nxt = '0;
    end else if (state_r == ST_EMIT && (!ov_r || out_ready)) begin
      ov_nxt = 1'b1;
      od_nxt = '0;
      od_nxt.code_point = code_r;
      od_nxt.pen_x = acc_r;
      if (gok_r) begin
        od_nxt.kind = KIND_FOUND;
        od_nxt.out_sprite_x = grd.sx;
        od_nxt.out_sprite_y = grd.sy;
        od_nxt.out_width = grd.w;
        od_nxt.out_height = grd.h;
        od_nxt.out_baseline = grd.bl;
        acc_nxt = nacc[16] ? 16'hFFFF : nacc[15:0];
        if (above > above_r) above_nxt = above;
        if (grd.bl > below_r) below_nxt = grd.bl;
      end else begin
        od_nxt.kind = KIND_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      emit_r  <= 1'b0;
      acc_r   <= '0;
      above_r <= '0;
      below_r <= '0;
    end else begin
      ov_r    <= ov_nxt;
      emit_r  <= 1'b0;
      acc_r   <= acc_nxt;
      above_r <= above_nxt;
      below_r <= below_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  `UGL_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != ST_IDLE, !in_ready)
  `UGL_ASSERT_NXT(a_lookup_starts, clk, rst_n, lookup, state_r == ST_PROBE)
  `UGL_ASSERT_IMP(a_kind_legal, clk, rst_n, out_valid, out_data.kind != KIND_RSVD)
endmodule

### tb/utf8_glyph_lookup_metrics_checker.sv
// checker for the utf8 glyph lookup block: watches the item channels and the
// register port, predicts each result and compares it. depends on ugl_pkg
`timescale 1ns / 100ps
module utf8_glyph_lookup_metrics_checker
  import ugl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [6:0] cfg_data,
  output int        fail_count,
  output int        pending_count
);
  range_rec_t ranges [NUM_RANGES];
  glyph_rec_t glyphs [NUM_GLYPHS];
  logic [1:0]  seq_left;
  logic [15:0] seq_code;
  logic [16:0] pen_accum;
  logic [7:0]  top_extent, bottom_extent;
  logic [3:0]  spacing;
  logic [6:0]  rcount;
  out_item_t   glyph_results [$];

  assign pending_count = glyph_results.size();

  function automatic out_item_t lookup_glyph(logic [15:0] code);
    out_item_t r;
    int n, lo, hi, mid, g;
    int unsigned first, stop;
    glyph_rec_t gr;
    r = '0;
    r.code_point = code;
    r.pen_x = pen_accum[15:0];
    r.kind = KIND_MISSING;
    n = (rcount > NUM_RANGES) ? NUM_RANGES : rcount;
    if (n == 0) return r;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (int'(ranges[mid].first) + int'(ranges[mid].len) > int'(code)) hi = mid;
      else lo = mid + 1;
    end
    first = ranges[lo].first;
    stop = first + ranges[lo].len;
    if (code < first || code >= stop) return r;
    g = ranges[lo].base + (code - first);
    if (g >= NUM_GLYPHS) return r;
    gr = glyphs[g];
    r.kind = KIND_FOUND;
    r.out_sprite_x = gr.sx;
    r.out_sprite_y = gr.sy;
    r.out_width = gr.w;
    r.out_height = gr.h;
    r.out_baseline = gr.bl;
    return r;
  endfunction

  task automatic place_glyph(logic [15:0] code);
    out_item_t r;
    int unsigned acc;
    r = lookup_glyph(code);
    if (r.kind == KIND_FOUND) begin
      acc = pen_accum + r.out_width + spacing;
      pen_accum = (acc > 16'hFFFF) ? 17'hFFFF : acc[16:0];
      if (r.out_height > r.out_baseline && r.out_height - r.out_baseline > top_extent)
        top_extent = r.out_height - r.out_baseline;
      if (r.out_baseline > bottom_extent) bottom_extent = r.out_baseline;
    end
    glyph_results = {glyph_results, r};
  endtask

  task automatic predict_item(in_item_t it);
    out_item_t r;
    case (it.command)
      CMD_RANGE: begin
        if (it.entry_index < NUM_RANGES)
          ranges[it.entry_index[RIDX_W-1:0]] = '{it.range_first_code, it.range_length,
                                                 it.range_glyph_base};
      end
      CMD_GLYPH: begin
        glyphs[it.entry_index] = '{it.glyph_baseline, it.glyph_h, it.glyph_w,
                                   it.glyph_sprite_y, it.glyph_sprite_x};
      end
      CMD_END: begin
        r = '0;
        r.kind = KIND_METRICS;
        if (pen_accum >= 16'hFFFF) r.line_width = 16'hFFFF;
        else if (pen_accum > spacing) r.line_width = 16'(pen_accum - spacing);
        r.above_baseline = top_extent;
        r.below_baseline = bottom_extent;
        glyph_results = {glyph_results, r};
        pen_accum = '0;
        top_extent = '0;
        bottom_extent = '0;
        seq_left = '0;
        seq_code = '0;
      end
      default: begin
        if (seq_left != 0) begin
          seq_code = {seq_code[9:0], it.text_byte[5:0]};
          seq_left--;
          if (seq_left == 0) begin
            place_glyph(seq_code);
            seq_code = '0;
          end
        end else if (!it.text_byte[7]) place_glyph({8'h00, it.text_byte});
        else if (it.text_byte[7:5] == 3'b110) begin
          seq_code = {11'd0, it.text_byte[4:0]};
          seq_left = 2'd1;
        end else if (it.text_byte[7:4] == 4'b1110) begin
          seq_code = {12'd0, it.text_byte[3:0]};
          seq_left = 2'd2;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      seq_left = '0;
      seq_code = '0;
      pen_accum = '0;
      top_extent = '0;
      bottom_extent = '0;
      spacing = 4'd1;
      rcount = '0;
      fail_count = 0;
      glyph_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SPACING) spacing = cfg_data[3:0];
        else rcount = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (glyph_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          want = glyph_results.pop_front();
          if (out_data !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, out_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_item(in_data);
    end
  end
endmodule

### tb/utf8_glyph_lookup_metrics_tb.sv
// top of the utf8 glyph lookup testbench: clock, reset, stimulus and verdict
// depends on ugl_pkg, the block and utf8_glyph_lookup_metrics_checker
`timescale 1ns / 100ps
module utf8_glyph_lookup_metrics_tb;
  import ugl_pkg::*;
  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic cfg_valid = 0, cfg_ready, cfg_index = 0;
  logic [6:0] cfg_data = 0;
  int fail_count, pending_count;
  int quiet_cycles = 0;
  bit no_idle = 0, hold_off = 0;
  int ranges_live = 0;

  always #5 clk = ~clk;

  utf8_glyph_lookup_metrics DUT (.*);
  utf8_glyph_lookup_metrics_checker u_checker (.*);

  // receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= no_idle || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge; valid stays up so the next item can follow directly
  task automatic send_item(in_item_t it);
    while (!no_idle && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_t idx, logic [6:0] val);
    in_valid <= 0;
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t text(logic [7:0] b);
    in_item_t it;
    it = rand_item();
    it.command = CMD_TEXT;
    it.text_byte = b;
    return it;
  endfunction

  function automatic in_item_t line_end();
    in_item_t it;
    it = rand_item();
    it.command = CMD_END;
    return it;
  endfunction

  task automatic load_range(int idx, int first, int len, int base);
    in_item_t it;
    it = rand_item();
    it.command = CMD_RANGE;
    it.entry_index = 10'(idx);
    it.range_first_code = 16'(first);
    it.range_length = 11'(len);
    it.range_glyph_base = 10'(base);
    send_item(it);
  endtask

  task automatic load_glyph(int idx, bit extreme);
    in_item_t it;
    it = rand_item();
    it.command = CMD_GLYPH;
    it.entry_index = 10'(idx);
    if (extreme) begin
      it.glyph_w = 8'hFF;
      it.glyph_h = 8'hFF;
    end
    send_item(it);
  endtask

  // encodes a code point as utf-8, occasionally breaking the sequence
  task automatic send_code(logic [15:0] cp);
    if (cp < 16'h80) send_item(text(cp[7:0]));
    else if (cp < 16'h800) begin
      send_item(text({3'b110, cp[10:6]}));
      send_item(text({$urandom_range(3) == 0 ? 2'($urandom) : 2'b10, cp[5:0]}));
    end else begin
      send_item(text({4'b1110, cp[15:12]}));
      send_item(text({2'b10, cp[11:6]}));
      send_item(text({2'b10, cp[5:0]}));
    end
  endtask

  // sorted, non-overlapping ranges covering small and large code points;
  // range 0 maps code point 0 onto the wide glyph 0, every entry is written
  task automatic load_tables(int n);
    int first;
    first = 0;
    for (int i = 0; i < n; i++) begin
      first += $urandom_range(40);
      if (i == 0) load_range(0, 0, 1, 0);
      else load_range(i, first, $urandom_range(3) == 0 ? 0 : $urandom_range(1, 40),
                      $urandom_range(59));
      first += 45;
    end
    load_range(n, 16'hFF00, 1024, 1000);
    for (int i = n + 1; i < NUM_RANGES; i++) load_range(i, 16'hFFFF, 0, 0);
    load_range($urandom_range(64, 1023), 0, 5, 0);
    ranges_live = NUM_RANGES;
  endtask

  task automatic random_line(int len, int span);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: send_item(text(8'($urandom)));
        1: send_item(text({5'b11110, 3'($urandom)}));
        2: send_code(16'(16'hFF00 + $urandom_range(1023)));
        default: send_code(16'($urandom_range(span)));
      endcase
    end
    send_item(line_end());
  endtask

  initial begin
    int sent_phase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // every glyph a range can reach is defined, so no read hits an unwritten entry
    no_idle = 1;
    for (int g = 0; g < 100; g++) load_glyph(g, g % 97 == 0);
    for (int g = 1000; g < NUM_GLYPHS; g++) load_glyph(g, 0);
    load_glyph(NUM_GLYPHS - 1, 1);
    no_idle = 0;
    load_tables(40);
    // directed: missing with zero ranges, then extremes and special cases
    send_item(text(8'h41));
    send_item(line_end());
    drain();
    write_reg(REG_RCOUNT, 7'd127);
    write_reg(REG_SPACING, 7'd15);
    send_item(text(8'h00));
    send_item(text(8'h7F));
    send_item(text(8'hC3));
    send_item(text(8'h3F));
    send_item(text(8'hE0));
    send_item(text(8'hFF));
    send_item(text(8'h01));
    send_item(text(8'hEF));
    send_item(text(8'hBF));
    send_item(text(8'hBF));
    send_item(text(8'hF5));
    send_item(text(8'h80));
    send_item(text(8'hC2));
    send_item(line_end());
    send_item(line_end());
    drain();
    write_reg(REG_SPACING, 7'd0);
    write_reg(REG_RCOUNT, 7'd0);
    send_item(text(8'h20));
    send_item(line_end());
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_SPACING, 7'(phase == 0 ? 15 : $urandom_range(15)));
      write_reg(REG_RCOUNT, 7'(phase == 1 ? 1 : (phase == 2 || phase == 5) ? 64 :
                $urandom_range(ranges_live + 2)));
      if (phase == 3) no_idle = 1;
      if (phase == 4) fork
        begin
          hold_off = 1;
          repeat (300) @(posedge clk);
          hold_off = 0;
        end
      join_none
      sent_phase = 0;
      while (sent_phase < 5) begin
        random_line($urandom_range(1, 8), 2000);
        sent_phase++;
      end
      // wide glyphs drive the line width into saturation
      if (phase == 5) begin
        for (int i = 0; i < 270; i++) send_item(text(8'h00));
        send_item(line_end());
      end
      no_idle = 0;
      drain();
    end
    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
